@@ sv/sbfc_pkg.sv @@
// Package with the constants, codes and memory sizes of the sprite blitter.
`timescale 1ns / 1ps
package sbfc_pkg;
	localparam int SRC_DEPTH = 16384;
	localparam int DST_DEPTH = 65536;
	localparam int SRC_AW = $clog2(SRC_DEPTH);
	localparam int DST_AW = $clog2(DST_DEPTH);
	localparam int EXT_AW = 21;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_BLIT = 2'd3;

	localparam logic [3:0] REG_SRC_W = 4'd0;
	localparam logic [3:0] REG_SRC_H = 4'd1;
	localparam logic [3:0] REG_DST_W = 4'd2;
	localparam logic [3:0] REG_DST_H = 4'd3;
	localparam logic [3:0] REG_COLS = 4'd4;
	localparam logic [3:0] REG_ROWS = 4'd5;
	localparam logic [3:0] REG_KEY_EN = 4'd6;
	localparam logic [3:0] REG_KEY_COL = 4'd7;

	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
	localparam logic [3:0] DIV_LAST = 4'd11;
endpackage

@@ sv/sprite_blit_flip_colorkey.sv @@
// Top level of the sprite blitter with tile selection, flips and colour key.
// A load, write or read request passes S_DONE and then gives its result in the output
// register; the input takes no new request until the block is back in S_IDLE.
// In a blit, a shared 12-step divider runs four times and a shared multiplier handles
// tile count, tile origin and row bases; each row then passes S_ROWS and S_ROWT, a pixel
// in range S_PIX and S_WR, a dropped pixel S_PIX alone; a stalled output holds the blit.
// Reset sets the configuration registers to their defaults and the sequencer to idle; the two memories are not cleared.
`timescale 1ns / 1ps
module sprite_blit_flip_colorkey (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// address, pixel, pos_x, pos_y, tile_index, flip, zero fill
	input  logic [79:0] s_tdata,
	// cmd
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_pixel, written_count, zero fill
	output logic [47:0] m_tdata,
	// out_of_range
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NTILE = 4'd1;
	localparam logic [3:0] S_DIVLD = 4'd2;
	localparam logic [3:0] S_DIV = 4'd3;
	localparam logic [3:0] S_DIVEND = 4'd4;
	localparam logic [3:0] S_MSX = 4'd5;
	localparam logic [3:0] S_MSY = 4'd6;
	localparam logic [3:0] S_CLIP = 4'd7;
	localparam logic [3:0] S_ROWS = 4'd8;
	localparam logic [3:0] S_ROWT = 4'd9;
	localparam logic [3:0] S_PIX = 4'd10;
	localparam logic [3:0] S_WR = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	localparam int DST_AW_L = sbfc_pkg::DST_AW;
	localparam int SRC_AW_L = sbfc_pkg::SRC_AW;

	logic [3:0] state_q;

	logic [10:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [6:0]  cols_q, rows_q;
	logic        key_en_q;
	logic [23:0] key_col_q;

	logic signed [15:0] tx_q, ty_q;
	logic [11:0] idx_q;
	logic [1:0]  flip_q;
	logic [12:0] ntiles_q;
	logic [5:0]  c_q, r_q;
	logic [10:0] tw_q, th_q;
	logic signed [15:0] sx_q, sy_q, cx_q, cy_q;
	logic signed [31:0] srow_q, trow_q;
	logic [11:0] i_q, j_q;
	logic [DST_AW_L-1:0] t_s1;

	logic [23:0] src_rd_q, dst_rd_q;
	logic [16:0] cnt_q;
	logic        oor_q, rd_cmd_q;

	logic [11:0] div_n_q;
	logic [12:0] div_d_q, div_r_q;
	logic [3:0]  div_cnt_q;
	logic [1:0]  div_step_q;

	logic        out_valid_q;
	logic [23:0] out_pixel_q;
	logic [16:0] out_cnt_q;
	logic        out_oor_q;

	logic [23:0] src_mem [sbfc_pkg::SRC_DEPTH];
	logic [23:0] dst_mem [sbfc_pkg::DST_DEPTH];

	logic [1:0]  in_cmd;
	logic [sbfc_pkg::EXT_AW-1:0] addr_ext;
	logic        accept, out_free, src_addr_ok, dst_addr_ok;

	assign in_cmd = s_tuser;
	assign addr_ext = {{(sbfc_pkg::EXT_AW - 16){1'b0}}, s_tdata[15:0]};
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_tready;
	assign src_addr_ok = addr_ext < sbfc_pkg::EXT_AW'(sbfc_pkg::SRC_DEPTH);
	assign dst_addr_ok = addr_ext < sbfc_pkg::EXT_AW'(sbfc_pkg::DST_DEPTH);

	// Shared divider step.
	logic [12:0] div_sh, div_rn;
	logic        div_ge;
	assign div_sh = {div_r_q[11:0], div_n_q[11]};
	assign div_ge = div_sh >= div_d_q;
	assign div_rn = div_ge ? div_sh - div_d_q : div_sh;

	// Current source row and column, with flips over the clipped extent.
	logic signed [15:0] i_s, j_s, yrow, xcol;
	assign i_s = {4'b0, i_q};
	assign j_s = {4'b0, j_q};
	assign yrow = flip_q[1] ? sy_q + cy_q - j_s - 16'sd1 : sy_q + j_s;
	assign xcol = flip_q[0] ? sx_q + cx_q - i_s - 16'sd1 : sx_q + i_s;

	// Shared multiplier.
	logic signed [15:0] mul_a, mul_b;
	logic signed [31:0] mul_p;
	always_comb begin
		unique case (state_q)
			S_NTILE: begin
				mul_a = {9'b0, cols_q};
				mul_b = {9'b0, rows_q};
			end
			S_MSX: begin
				mul_a = {10'b0, c_q};
				mul_b = {5'b0, tw_q};
			end
			S_MSY: begin
				mul_a = {10'b0, r_q};
				mul_b = {5'b0, th_q};
			end
			S_ROWS: begin
				mul_a = $signed({5'b0, src_h_q}) - yrow - 16'sd1;
				mul_b = {5'b0, src_w_q};
			end
			S_ROWT: begin
				mul_a = $signed({5'b0, dst_h_q}) - ty_q - j_s - 16'sd1;
				mul_b = {5'b0, dst_w_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Clipping of the tile to the frame.
	logic signed [15:0] clip_cx, clip_cy, clip_sx, clip_sy, clip_tx, clip_ty;
	logic signed [15:0] w1_s, h1_s;
	assign w1_s = {5'b0, dst_w_q};
	assign h1_s = {5'b0, dst_h_q};
	always_comb begin
		clip_cx = {5'b0, tw_q};
		clip_cy = {5'b0, th_q};
		clip_sx = sx_q;
		clip_sy = sy_q;
		clip_tx = tx_q;
		clip_ty = ty_q;
		if (tx_q + clip_cx >= w1_s) begin
			clip_cx = w1_s - tx_q;
		end
		if (ty_q + clip_cy >= h1_s) begin
			clip_cy = h1_s - ty_q;
		end
		if (tx_q < 16'sd0) begin
			clip_sx = sx_q - tx_q;
			clip_cx = clip_cx + tx_q;
			clip_tx = 16'sd0;
		end
		if (ty_q < 16'sd0) begin
			clip_sy = sy_q - ty_q;
			clip_cy = clip_cy + ty_q;
			clip_ty = 16'sd0;
		end
	end

	// Pixel addresses and range checks.
	logic signed [31:0] s_addr, t_addr;
	logic        pix_ok, last_col, last_row, key_hit;
	logic [23:0] key_pix;
	assign s_addr = srow_q + {{16{xcol[15]}}, xcol};
	assign t_addr = trow_q + {20'b0, i_q};
	assign pix_ok = (s_addr >= 32'sd0) && (s_addr < 32'(sbfc_pkg::SRC_DEPTH))
		&& (t_addr >= 32'sd0) && (t_addr < 32'(sbfc_pkg::DST_DEPTH));
	assign last_col = (i_s + 16'sd1) >= cx_q;
	assign last_row = (j_s + 16'sd1) >= cy_q;
	assign key_pix = {key_col_q[7:0], key_col_q[15:8], key_col_q[23:16]};
	assign key_hit = key_en_q && (src_rd_q == key_pix);

	logic [3:0] next_pix_state;
	assign next_pix_state = !last_col ? S_PIX : (!last_row ? S_ROWS : S_DONE);

	// Source memory.
	always_ff @(posedge clk) begin
		if (accept && in_cmd == sbfc_pkg::CMD_LOAD && src_addr_ok) begin
			src_mem[addr_ext[SRC_AW_L-1:0]] <= s_tdata[39:16];
		end
		if (state_q == S_PIX) begin
			src_rd_q <= src_mem[s_addr[SRC_AW_L-1:0]];
		end
	end

	// Destination memory.
	logic                dst_we;
	logic [DST_AW_L-1:0] dst_wa;
	logic [23:0]         dst_wd;
	always_comb begin
		dst_we = 1'b0;
		dst_wa = addr_ext[DST_AW_L-1:0];
		dst_wd = s_tdata[39:16];
		if (accept && in_cmd == sbfc_pkg::CMD_WRITE && dst_addr_ok) begin
			dst_we = 1'b1;
		end else if (state_q == S_WR && !key_hit) begin
			dst_we = 1'b1;
			dst_wa = t_s1;
			dst_wd = src_rd_q;
		end
	end
	always_ff @(posedge clk) begin
		if (dst_we) begin
			dst_mem[dst_wa] <= dst_wd;
		end
		if (accept && in_cmd == sbfc_pkg::CMD_READ && dst_addr_ok) begin
			dst_rd_q <= dst_mem[addr_ext[DST_AW_L-1:0]];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 11'd64;
			src_h_q <= 11'd64;
			dst_w_q <= 11'd256;
			dst_h_q <= 11'd256;
			cols_q <= 7'd1;
			rows_q <= 7'd1;
			key_en_q <= 1'b0;
			key_col_q <= 24'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sbfc_pkg::REG_SRC_W: src_w_q <= cfg_data[10:0];
				sbfc_pkg::REG_SRC_H: src_h_q <= cfg_data[10:0];
				sbfc_pkg::REG_DST_W: dst_w_q <= cfg_data[10:0];
				sbfc_pkg::REG_DST_H: dst_h_q <= cfg_data[10:0];
				sbfc_pkg::REG_COLS: cols_q <= cfg_data[6:0];
				sbfc_pkg::REG_ROWS: rows_q <= cfg_data[6:0];
				sbfc_pkg::REG_KEY_EN: key_en_q <= cfg_data[0];
				sbfc_pkg::REG_KEY_COL: key_col_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_cnt_q <= '0;
			div_step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (in_cmd == sbfc_pkg::CMD_BLIT) ? S_NTILE : S_DONE;
					end
				end
				S_NTILE: begin
					div_step_q <= 2'd0;
					state_q <= (cols_q == 7'd0 || rows_q == 7'd0) ? S_DONE : S_DIVLD;
				end
				S_DIVLD: begin
					div_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == sbfc_pkg::DIV_LAST) begin
						state_q <= S_DIVEND;
					end
				end
				S_DIVEND: begin
					div_step_q <= div_step_q + 2'd1;
					state_q <= (div_step_q == 2'd3) ? S_MSX : S_DIVLD;
				end
				S_MSX: state_q <= S_MSY;
				S_MSY: state_q <= S_CLIP;
				S_CLIP: begin
					state_q <= (clip_cx <= 16'sd0 || clip_cy <= 16'sd0) ? S_DONE : S_ROWS;
				end
				S_ROWS: state_q <= S_ROWT;
				S_ROWT: state_q <= S_PIX;
				S_PIX: state_q <= pix_ok ? S_WR : next_pix_state;
				S_WR: state_q <= next_pix_state;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_cmd_q <= (in_cmd == sbfc_pkg::CMD_READ);
					cnt_q <= '0;
					oor_q <= ((in_cmd == sbfc_pkg::CMD_LOAD) && !src_addr_ok)
						|| ((in_cmd != sbfc_pkg::CMD_LOAD) && (in_cmd != sbfc_pkg::CMD_BLIT)
						&& !dst_addr_ok);
					tx_q <= {{5{s_tdata[50]}}, s_tdata[50:40]};
					ty_q <= {{5{s_tdata[61]}}, s_tdata[61:51]};
					idx_q <= s_tdata[73:62];
					flip_q <= s_tdata[75:74];
				end
			end
			S_NTILE: ntiles_q <= mul_p[12:0];
			S_DIVLD: begin
				div_r_q <= '0;
				case (div_step_q)
					2'd0: begin
						div_n_q <= idx_q;
						div_d_q <= ntiles_q;
					end
					2'd1: begin
						div_n_q <= idx_q;
						div_d_q <= {6'b0, cols_q};
					end
					2'd2: begin
						div_n_q <= {1'b0, src_w_q};
						div_d_q <= {6'b0, cols_q};
					end
					default: begin
						div_n_q <= {1'b0, src_h_q};
						div_d_q <= {6'b0, rows_q};
					end
				endcase
			end
			S_DIV: begin
				div_r_q <= div_rn;
				div_n_q <= {div_n_q[10:0], div_ge};
			end
			S_DIVEND: begin
				case (div_step_q)
					2'd0: idx_q <= div_r_q[11:0];
					2'd1: begin
						r_q <= div_n_q[5:0];
						c_q <= div_r_q[5:0];
					end
					2'd2: tw_q <= div_n_q[10:0];
					default: th_q <= div_n_q[10:0];
				endcase
			end
			S_MSX: sx_q <= mul_p[15:0];
			S_MSY: sy_q <= mul_p[15:0];
			S_CLIP: begin
				cx_q <= clip_cx;
				cy_q <= clip_cy;
				sx_q <= clip_sx;
				sy_q <= clip_sy;
				tx_q <= clip_tx;
				ty_q <= clip_ty;
				j_q <= '0;
			end
			S_ROWS: srow_q <= mul_p;
			S_ROWT: begin
				trow_q <= mul_p + {{16{tx_q[15]}}, tx_q};
				i_q <= '0;
			end
			S_PIX: begin
				if (pix_ok) begin
					t_s1 <= t_addr[DST_AW_L-1:0];
				end else begin
					oor_q <= 1'b1;
					if (!last_col) begin
						i_q <= i_q + 12'd1;
					end else begin
						j_q <= j_q + 12'd1;
					end
				end
			end
			S_WR: begin
				if (!key_hit && cnt_q != sbfc_pkg::COUNT_MAX) begin
					cnt_q <= cnt_q + 17'd1;
				end
				if (!last_col) begin
					i_q <= i_q + 12'd1;
				end else begin
					j_q <= j_q + 12'd1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_pixel_q <= rd_cmd_q && !oor_q ? dst_rd_q : 24'd0;
					out_cnt_q <= cnt_q;
					out_oor_q <= oor_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'b0, out_cnt_q, out_pixel_q};
	assign m_tuser = out_oor_q;

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q <= sbfc_pkg::DIV_LAST + 4'd1)
		else $error("Divider step count ran past its last step.");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (m_tvalid && state_q == S_IDLE))
		else $error("Finished request did not reach the output register.");
	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_pixel_q != 24'd0) |-> (out_cnt_q == 17'd0))
		else $error("Read result carries a write count.");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIX || state_q == S_WR) |-> (cx_q > 16'sd0 && cy_q > 16'sd0))
		else $error("Pixel loop entered with an empty clipped extent.");
endmodule

@@ sim/blit_checker.sv @@
// Checker for the sprite blitter: predicts every result and compares it with the block's output.
`timescale 1ns / 1ps
module blit_checker (
	input  logic        clk,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [23:0] read_pixel;
		logic [16:0] written_count;
		logic        out_of_range;
	} blit_result_t;

	logic [23:0] sheet_mem [sbfc_pkg::SRC_DEPTH];
	logic [23:0] frame_mem [sbfc_pkg::DST_DEPTH];
	logic [10:0] sheet_w = 11'd64, sheet_h = 11'd64, frame_w = 11'd256, frame_h = 11'd256;
	logic [6:0]  grid_cols = 7'd1, grid_rows = 7'd1;
	logic        key_on = 1'b0;
	logic [23:0] key_rgb = 24'd0;
	blit_result_t expected_results [$];
	int          err_q = 0;
	int          pending_q = 0;

	assign errors = err_q;
	assign pending = pending_q;

	function automatic blit_result_t run_request(input logic [1:0] cmd, input logic [15:0] addr,
			input logic [23:0] pix, input logic signed [10:0] px, input logic signed [10:0] py,
			input logic [11:0] ti, input logic [1:0] fl);
		blit_result_t res;
		longint tx, ty, tw, th, sx, sy, cx, cy, ntiles, idx, c, r, x, y, s, t;
		logic [23:0] keypix, sp;
		res = '0;
		case (cmd)
			sbfc_pkg::CMD_LOAD: begin
				if (addr < sbfc_pkg::SRC_DEPTH) sheet_mem[addr] = pix;
				else res.out_of_range = 1'b1;
			end
			sbfc_pkg::CMD_WRITE: begin
				if (addr < sbfc_pkg::DST_DEPTH) frame_mem[addr] = pix;
				else res.out_of_range = 1'b1;
			end
			sbfc_pkg::CMD_READ: begin
				if (addr < sbfc_pkg::DST_DEPTH) res.read_pixel = frame_mem[addr];
				else res.out_of_range = 1'b1;
			end
			default: begin
				keypix = {key_rgb[7:0], key_rgb[15:8], key_rgb[23:16]};
				if (grid_cols != 0 && grid_rows != 0) begin
					tx = longint'(px);
					ty = longint'(py);
					ntiles = longint'(grid_cols) * longint'(grid_rows);
					idx = longint'(ti) % ntiles;
					c = idx % longint'(grid_cols);
					r = idx / longint'(grid_cols);
					tw = longint'(sheet_w) / longint'(grid_cols);
					th = longint'(sheet_h) / longint'(grid_rows);
					sx = c * tw;
					sy = r * th;
					cx = tw;
					cy = th;
					if (tx + cx >= longint'(frame_w)) cx = longint'(frame_w) - tx;
					if (ty + cy >= longint'(frame_h)) cy = longint'(frame_h) - ty;
					if (tx < 0) begin sx -= tx; cx += tx; tx = 0; end
					if (ty < 0) begin sy -= ty; cy += ty; ty = 0; end
					for (longint j = 0; j < cy; j++) begin
						for (longint i = 0; i < cx; i++) begin
							x = fl[0] ? sx + cx - i - 1 : sx + i;
							y = fl[1] ? sy + cy - j - 1 : sy + j;
							s = (longint'(sheet_h) - y - 1) * longint'(sheet_w) + x;
							t = (longint'(frame_h) - ty - j - 1) * longint'(frame_w) + tx + i;
							if (s < 0 || s >= sbfc_pkg::SRC_DEPTH || t < 0
									|| t >= sbfc_pkg::DST_DEPTH) begin
								res.out_of_range = 1'b1;
							end else begin
								sp = sheet_mem[s];
								if (!(key_on && sp == keypix)) begin
									frame_mem[t] = sp;
									if (res.written_count != sbfc_pkg::COUNT_MAX)
										res.written_count = res.written_count + 17'd1;
								end
							end
						end
					end
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk) begin
		blit_result_t exp_res;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sbfc_pkg::REG_SRC_W:   sheet_w <= cfg_data[10:0];
				sbfc_pkg::REG_SRC_H:   sheet_h <= cfg_data[10:0];
				sbfc_pkg::REG_DST_W:   frame_w <= cfg_data[10:0];
				sbfc_pkg::REG_DST_H:   frame_h <= cfg_data[10:0];
				sbfc_pkg::REG_COLS:    grid_cols <= cfg_data[6:0];
				sbfc_pkg::REG_ROWS:    grid_rows <= cfg_data[6:0];
				sbfc_pkg::REG_KEY_EN:  key_on <= cfg_data[0];
				sbfc_pkg::REG_KEY_COL: key_rgb <= cfg_data;
				default: ;
			endcase
		end
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request outstanding: %h %h",
					$time, m_tdata, m_tuser);
				err_q <= err_q + 1;
			end else begin
				exp_res = expected_results.pop_front();
				if (m_tdata[23:0] !== exp_res.read_pixel ||
						m_tdata[40:24] !== exp_res.written_count ||
						m_tuser[0] !== exp_res.out_of_range) begin
					$display({"%0t: mismatch expected pixel %h count %0d oor %b",
						" actual pixel %h count %0d oor %b"},
						$time, exp_res.read_pixel, exp_res.written_count,
						exp_res.out_of_range, m_tdata[23:0], m_tdata[40:24], m_tuser[0]);
					err_q <= err_q + 1;
				end
			end
		end
		if (s_tvalid && s_tready)
			expected_results.push_back(run_request(s_tuser, s_tdata[15:0], s_tdata[39:16],
				s_tdata[50:40], s_tdata[61:51], s_tdata[73:62], s_tdata[75:74]));
		pending_q <= expected_results.size();
	end
endmodule

@@ sim/testbench.sv @@
// Top of the sprite blitter testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
	localparam int TOTAL_ITEMS = 1950;
	localparam int CYCLE_LIMIT = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	int          errors;
	int          pending;

	int          cycles = 0;
	int          item_count = 0;
	bit          calm = 1'b0;
	int          stall = 0;
	int          long_hold = 0;
	bit          sheet_loaded [sbfc_pkg::SRC_DEPTH];
	logic [15:0] frame_written [$];
	int          sheet_w = 64, sheet_h = 64, frame_w = 256, frame_h = 256;
	int          grid_cols = 1, grid_rows = 1;
	logic [23:0] key_rgb = 24'd0;

	sprite_blit_flip_colorkey i_dut (.*);

	blit_checker i_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 1500 == 0) calm <= ($urandom_range(0, 3) == 0);
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stalls after each result, and one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cycles == 4000) long_hold = 600;
			if (long_hold > 0) begin
				long_hold--;
				m_tready <= 1'b0;
			end else begin
				if (m_tvalid && m_tready) stall = calm ? 0 : $urandom_range(0, 8);
				if (stall > 0) begin
					stall--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
			input logic [23:0] pix, input logic [10:0] px, input logic [10:0] py,
			input logic [11:0] ti, input logic [1:0] fl);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'd0, fl, ti, py, px, pix, addr};
		do @(posedge clk); while (!s_tready);
		item_count++;
		if (cmd == sbfc_pkg::CMD_WRITE) frame_written.push_back(addr);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [3:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[23:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_geometry(input int sw, input int sh, input int dw, input int dh,
			input int cols, input int rows, input bit key_on, input logic [23:0] kc);
		wait_idle();
		sheet_w = sw; sheet_h = sh; frame_w = dw; frame_h = dh;
		grid_cols = cols; grid_rows = rows; key_rgb = kc;
		cfg_write(sbfc_pkg::REG_SRC_W, sw);
		cfg_write(sbfc_pkg::REG_SRC_H, sh);
		cfg_write(sbfc_pkg::REG_DST_W, dw);
		cfg_write(sbfc_pkg::REG_DST_H, dh);
		cfg_write(sbfc_pkg::REG_COLS, cols);
		cfg_write(sbfc_pkg::REG_ROWS, rows);
		cfg_write(sbfc_pkg::REG_KEY_EN, {31'd0, key_on});
		cfg_write(sbfc_pkg::REG_KEY_COL, {8'd0, kc});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [23:0] sheet_pixel();
		if ($urandom_range(0, 3) == 0) return {key_rgb[7:0], key_rgb[15:8], key_rgb[23:16]};
		return 24'($urandom_range(0, 24'hFFFFFF));
	endfunction

	// Loads every sheet pixel that the blit will fetch and that holds nothing yet.
	task automatic blit_tile(input int px, input int py, input logic [11:0] ti,
			input logic [1:0] fl);
		longint tx, ty, tw, th, sx, sy, cx, cy, idx, s, t;
		tx = px;
		ty = py;
		idx = longint'(ti) % (grid_cols * grid_rows);
		tw = sheet_w / grid_cols;
		th = sheet_h / grid_rows;
		sx = (idx % grid_cols) * tw;
		sy = (idx / grid_cols) * th;
		cx = tw;
		cy = th;
		if (tx + cx >= frame_w) cx = frame_w - tx;
		if (ty + cy >= frame_h) cy = frame_h - ty;
		if (tx < 0) begin sx -= tx; cx += tx; tx = 0; end
		if (ty < 0) begin sy -= ty; cy += ty; ty = 0; end
		for (longint j = 0; j < cy; j++) begin
			for (longint i = 0; i < cx; i++) begin
				s = (sheet_h - sy - j - 1) * sheet_w + sx + i;
				t = (frame_h - ty - j - 1) * frame_w + tx + i;
				if (s >= 0 && s < sbfc_pkg::SRC_DEPTH && t >= 0 && t < sbfc_pkg::DST_DEPTH
						&& !sheet_loaded[s]) begin
					sheet_loaded[s] = 1'b1;
					send_request(sbfc_pkg::CMD_LOAD, s[15:0], sheet_pixel(), '0, '0, '0, '0);
				end
			end
		end
		send_request(sbfc_pkg::CMD_BLIT, 16'($urandom_range(0, 16'hFFFF)),
			24'($urandom_range(0, 24'hFFFFFF)), px[10:0], py[10:0], ti, fl);
	endtask

	task automatic random_item();
		int kind, tw, th, px, py;
		logic [15:0] addr;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			addr = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF))
				: 16'($urandom_range(0, sbfc_pkg::SRC_DEPTH - 1));
			if (addr < sbfc_pkg::SRC_DEPTH) sheet_loaded[addr] = 1'b1;
			send_request(sbfc_pkg::CMD_LOAD, addr, sheet_pixel(), 11'($urandom),
				11'($urandom), 12'($urandom), 2'($urandom));
		end else if (kind < 38 || frame_written.size() == 0) begin
			send_request(sbfc_pkg::CMD_WRITE, 16'($urandom_range(0, 16'hFFFF)),
				24'($urandom_range(0, 24'hFFFFFF)), 11'($urandom), 11'($urandom),
				12'($urandom), 2'($urandom));
		end else if (kind < 55) begin
			addr = frame_written[$urandom_range(0, frame_written.size() - 1)];
			send_request(sbfc_pkg::CMD_READ, addr, 24'($urandom_range(0, 24'hFFFFFF)),
				11'($urandom), 11'($urandom), 12'($urandom), 2'($urandom));
		end else begin
			tw = sheet_w / grid_cols;
			th = sheet_h / grid_rows;
			if ($urandom_range(0, 4) == 0) begin
				px = $signed(11'($urandom));
				py = $signed(11'($urandom));
			end else begin
				px = $urandom_range(0, frame_w + tw + 3) - tw - 2;
				py = $urandom_range(0, frame_h + th + 3) - th - 2;
				if (px > 1023) px = 1023;
				if (py > 1023) py = 1023;
				if (px < -1024) px = -1024;
				if (py < -1024) py = -1024;
			end
			blit_tile(px, py, 12'($urandom_range(0, 12'hFFF)), 2'($urandom_range(0, 3)));
		end
	endtask

	task automatic random_phase(input int len);
		int target;
		target = item_count + len;
		while (item_count < target && item_count < TOTAL_ITEMS) random_item();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Default geometry: memory ends, addresses past the depth, fully clipped blits.
		sheet_loaded[0] = 1'b1;
		sheet_loaded[sbfc_pkg::SRC_DEPTH - 1] = 1'b1;
		send_request(sbfc_pkg::CMD_LOAD, 16'd0, 24'd0, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_LOAD, 16'(sbfc_pkg::SRC_DEPTH - 1), 24'hFFFFFF,
			'0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_LOAD, 16'(sbfc_pkg::SRC_DEPTH), 24'h123456,
			'0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_LOAD, 16'hFFFF, 24'hABCDEF, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_WRITE, 16'd0, 24'hFFFFFF, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_WRITE, 16'hFFFF, 24'h000000, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_WRITE, 16'd12345, 24'hA5A5A5, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_READ, 16'd0, '0, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_READ, 16'hFFFF, '0, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_READ, 16'd12345, '0, '0, '0, '0, '0);
		send_request(sbfc_pkg::CMD_BLIT, '0, '0, 11'h3FF, 11'h3FF, 12'hFFF, 2'd3);
		send_request(sbfc_pkg::CMD_BLIT, '0, '0, 11'h400, 11'h400, 12'h000, 2'd0);

		// Small grid with keying: every flip, clipping on each side.
		set_geometry(8, 8, 16, 16, 2, 2, 1'b1, 24'h00FF80);
		blit_tile(3, 4, 12'd0, 2'd0);
		blit_tile(3, 4, 12'd1, 2'd1);
		blit_tile(3, 4, 12'd2, 2'd2);
		blit_tile(3, 4, 12'd7, 2'd3);
		blit_tile(-2, -1, 12'd5, 2'd1);
		blit_tile(14, 13, 12'd6, 2'd3);
		send_request(sbfc_pkg::CMD_READ, 16'd12345, '0, '0, '0, '0, '0);
		random_phase(150);

		// Tile size of zero.
		set_geometry(8, 8, 32, 32, 64, 64, 1'b0, 24'hFFFFFF);
		random_phase(60);

		// Largest sizes: most fetches fall past the memory depth.
		set_geometry(1024, 1024, 1024, 1024, 64, 64, 1'b1, 24'h000000);
		blit_tile(0, 1010, 12'd4032, 2'd0);
		blit_tile(-5, 1020, 12'd4095, 2'd3);
		blit_tile(1015, 1000, 12'd4040, 2'd1);
		random_phase(80);

		// Single pixel everywhere.
		set_geometry(1, 1, 1, 1, 1, 1, 1'b1, 24'h808080);
		random_phase(80);

		set_geometry(48, 32, 256, 256, 1, 1, 1'b0, 24'h000000);
		random_phase(40);

		while (item_count < TOTAL_ITEMS) begin
			set_geometry($urandom_range(1, 48), $urandom_range(1, 48), $urandom_range(1, 128),
				$urandom_range(1, 128), $urandom_range(1, 8), $urandom_range(1, 8),
				1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)));
			random_phase(150);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
